@@ hdl/aff2d_pkg.sv @@
// Shared types, constants and tables of the 2D affine transform engine.
`default_nettype none
package aff2d_pkg;

    localparam logic [2:0] OP_IDENTITY  = 3'd0;
    localparam logic [2:0] OP_TRANSLATE = 3'd1;
    localparam logic [2:0] OP_ROTATE    = 3'd2;
    localparam logic [2:0] OP_SCALE     = 3'd3;
    localparam logic [2:0] OP_SHEAR     = 3'd4;
    localparam logic [2:0] OP_POINT     = 3'd5;

    localparam int CNT_W     = 6;
    localparam int CORD_W    = 34;
    localparam int ACC_W     = 66;
    localparam logic [CORD_W-1:0] CORDIC_GAIN_Q30 = CORD_W'(652032874);

    typedef struct packed {
        logic             capture;
        logic             identity;
        logic             div_quot;
        logic             mod_done;
        logic             div_next;
        logic             div_digit;
        logic             cordic_init;
        logic             cordic_step;
        logic             trig_load;
        logic             mul;
        logic             acc_first;
        logic             acc_add;
        logic             store;
        logic             commit;
        logic             emit;
        logic             k;
        logic             row;
        logic [1:0]       col;
        logic [CNT_W-1:0] cnt;
    } t_cmd;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000028;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000002;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ hdl/aff2d_ctrl.sv @@
// Sequencer of the 2D affine transform engine: issues datapath commands per request.
`default_nettype none
module aff2d_ctrl
    import aff2d_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire logic [2:0] i_operation,
    output logic            busy,
    output t_cmd            o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_QUOT   = 4'd1;
    localparam logic [3:0] S_MODR   = 4'd2;
    localparam logic [3:0] S_DIVN   = 4'd3;
    localparam logic [3:0] S_DIG    = 4'd4;
    localparam logic [3:0] S_CINIT  = 4'd5;
    localparam logic [3:0] S_CORD   = 4'd6;
    localparam logic [3:0] S_TRIG   = 4'd7;
    localparam logic [3:0] S_MUL0   = 4'd8;
    localparam logic [3:0] S_ACC0   = 4'd9;
    localparam logic [3:0] S_MUL1   = 4'd10;
    localparam logic [3:0] S_ACC1   = 4'd11;
    localparam logic [3:0] S_STORE  = 4'd12;
    localparam logic [3:0] S_COMMIT = 4'd13;
    localparam logic [3:0] S_EMIT   = 4'd14;

    localparam logic [CNT_W-1:0] PH_MOD    = CNT_W'(0);
    localparam logic [CNT_W-1:0] PH_HI     = CNT_W'(1);
    localparam logic [CNT_W-1:0] PH_LO     = CNT_W'(2);
    localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(CORDIC_STEPS - 1);

    logic [3:0]       r_state, n_state;
    logic             r_point, n_point;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_row, n_row;
    logic [1:0]       r_col, n_col;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_point = r_point;
        n_cnt   = r_cnt;
        n_row   = r_row;
        n_col   = r_col;
        o_cmd   = '0;
        o_cmd.k   = 1'b0;
        o_cmd.row = r_row;
        o_cmd.col = r_col;
        o_cmd.cnt = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_cnt   = '0;
                    n_row   = 1'b0;
                    n_col   = (i_operation == OP_POINT) ? 2'd2 : 2'd0;
                    n_point = (i_operation == OP_POINT);
                    priority if (i_operation == OP_IDENTITY) begin
                        o_cmd.identity = 1'b1;
                    end else if (i_operation == OP_ROTATE) begin
                        n_state = S_QUOT;
                    end else if (i_operation == OP_TRANSLATE || i_operation == OP_SCALE ||
                                 i_operation == OP_SHEAR || i_operation == OP_POINT) begin
                        n_state = S_MUL0;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_QUOT: begin
                o_cmd.div_quot = 1'b1;
                n_state = (r_cnt == PH_MOD) ? S_MODR : S_DIG;
            end
            S_MODR: begin
                o_cmd.mod_done = 1'b1;
                n_state = S_DIVN;
            end
            S_DIVN: begin
                o_cmd.div_next = 1'b1;
                n_cnt   = PH_HI;
                n_state = S_QUOT;
            end
            S_DIG: begin
                o_cmd.div_digit = 1'b1;
                if (r_cnt == PH_LO) begin
                    n_cnt   = '0;
                    n_state = S_CINIT;
                end else begin
                    n_cnt   = PH_LO;
                    n_state = S_QUOT;
                end
            end
            S_CINIT: begin
                o_cmd.cordic_init = 1'b1;
                n_cnt   = '0;
                n_state = S_CORD;
            end
            S_CORD: begin
                o_cmd.cordic_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CORD_LAST) begin
                    n_state = S_TRIG;
                end
            end
            S_TRIG: begin
                o_cmd.trig_load = 1'b1;
                n_state = S_MUL0;
            end
            S_MUL0: begin
                o_cmd.mul = 1'b1;
                n_state = S_ACC0;
            end
            S_ACC0: begin
                o_cmd.acc_first = 1'b1;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul = 1'b1;
                o_cmd.k   = 1'b1;
                n_state = S_ACC1;
            end
            S_ACC1: begin
                o_cmd.acc_add = 1'b1;
                n_state = S_STORE;
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_state = S_MUL0;
                if (r_col == 2'd2) begin
                    n_row = 1'b1;
                    n_col = r_point ? 2'd2 : 2'd0;
                    if (r_row) begin
                        n_state = r_point ? S_EMIT : S_COMMIT;
                    end
                end else begin
                    n_col = r_col + 2'd1;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state = S_IDLE;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_point <= 1'b0;
            r_cnt   <= '0;
            r_row   <= 1'b0;
            r_col   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_point <= n_point;
            r_cnt   <= n_cnt;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

endmodule
`default_nettype wire

@@ hdl/aff2d_datapath.sv @@
// Datapath: matrix store, angle divider, CORDIC, shared multiplier and accumulator.
`default_nettype none
module aff2d_datapath
    import aff2d_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire logic [2:0]         i_operation,
    input  wire logic signed [31:0] i_arg_a,
    input  wire logic signed [31:0] i_arg_b,
    input  wire logic               i_shear_axis,
    output logic signed [31:0]      o_x_out,
    output logic signed [31:0]      o_y_out,
    output logic                    o_overflow,
    output logic                    o_valid
);

    localparam int RW = FRAC_BITS + 10;
    localparam int SH = 30 - FRAC_BITS;
    localparam int DX_W = 25;
    localparam logic [RW-1:0] FULL = RW'(360) << FRAC_BITS;
    localparam logic [25:0] RECIP_360 = 26'd47721859;
    localparam logic [DX_W-1:0] DVS = DX_W'(360);
    localparam logic [9:0] TURN_DEG = 10'd360;
    localparam logic signed [31:0] ONE = 32'(1) << FRAC_BITS;
    localparam logic signed [CORD_W-1:0] HALF_T = (CORD_W'(1) << SH) >> 1;
    localparam logic signed [63:0] HALF_M = 64'(1) << (FRAC_BITS - 1);

    logic signed [31:0]       r_m [6];
    logic signed [31:0]       r_t [6];
    logic signed [31:0]       r_res [6];
    logic                     r_neg;
    logic [DX_W-1:0]          r_dx;
    logic [15:0]              r_dq;
    logic [FRAC_BITS-1:0]     r_lo;
    logic [RW-1:0]            r_rmod;
    logic [15:0]              r_d0;
    logic [31:0]              r_bin;
    logic [1:0]               r_q;
    logic signed [CORD_W-1:0] r_phi, r_x, r_y;
    logic signed [63:0]       r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_ovf;
    logic                     r_valid;

    logic [31:0]              a_mag;
    logic [50:0]              dprod;
    logic [DX_W-1:0]          dr;
    logic [RW-1:0]            rem_v;
    logic [RW-1:0]            rmod_v;
    logic [32:0]              low_n;
    logic [9:0]               rhi_n;
    logic [9:0]               rem0_n;
    logic [31:0]              bin;
    logic [1:0]               quad;
    logic [4:0]               ci;
    logic signed [CORD_W-1:0] dx, dy, at;
    logic signed [CORD_W-1:0] cq, sq, cr, sr;
    logic signed [31:0]       ma, tb, cterm;
    logic signed [63:0]       prod, prod_r;
    logic signed [ACC_W-1:0]  rp;
    logic                     sat_hit;
    logic signed [31:0]       sat_val;

    assign a_mag  = i_arg_a[31] ? (32'd0 - i_arg_a) : i_arg_a;
    assign dprod  = 51'(r_dx) * 51'(RECIP_360);
    assign dr     = r_dx - DX_W'(r_dq) * DVS;
    assign rem_v  = RW'({dr[8:0], r_lo});
    assign rmod_v = (r_neg && rem_v != '0) ? (FULL - rem_v) : rem_v;
    assign low_n  = 33'({r_rmod[FRAC_BITS-1:0], {(32-FRAC_BITS){1'b0}}}) + 33'd180;
    assign rhi_n  = r_rmod[RW-1:FRAC_BITS] + {9'd0, low_n[32]};
    assign rem0_n = (rhi_n == TURN_DEG) ? 10'd0 : rhi_n;

    assign bin  = r_bin;
    assign quad = bin[31:30] + {1'b0, bin[29]};

    assign ci = i_cmd.cnt[4:0];
    assign dx = r_y >>> ci;
    assign dy = r_x >>> ci;
    assign at = CORD_W'(atan_turn(ci));

    always_comb begin
        unique case (r_q)
            2'd0: begin
                cq = r_x;
                sq = r_y;
            end
            2'd1: begin
                cq = -r_y;
                sq = r_x;
            end
            2'd2: begin
                cq = -r_x;
                sq = -r_y;
            end
            default: begin
                cq = r_y;
                sq = -r_x;
            end
        endcase
        cr = (cq + HALF_T) >>> SH;
        sr = (sq + HALF_T) >>> SH;
    end

    always_comb begin
        unique case ({i_cmd.row, i_cmd.k})
            2'b00:   ma = r_m[0];
            2'b01:   ma = r_m[1];
            2'b10:   ma = r_m[3];
            default: ma = r_m[4];
        endcase
        unique case ({i_cmd.k, i_cmd.col})
            3'b000:  tb = r_t[0];
            3'b001:  tb = r_t[1];
            3'b010:  tb = r_t[2];
            3'b100:  tb = r_t[3];
            3'b101:  tb = r_t[4];
            3'b110:  tb = r_t[5];
            default: tb = 32'sd0;
        endcase
        if (i_cmd.col == 2'd2) begin
            cterm = i_cmd.row ? r_m[5] : r_m[2];
        end else begin
            cterm = 32'sd0;
        end
    end

    assign prod    = ma * tb;
    assign prod_r  = (r_prod + HALF_M) >>> FRAC_BITS;
    assign rp      = ACC_W'(prod_r);
    assign sat_hit = (r_acc[ACC_W-1:31] != {(ACC_W-31){r_acc[31]}});
    assign sat_val = sat_hit ? (r_acc[ACC_W-1] ? 32'sh80000000 : 32'sh7fffffff)
                             : r_acc[31:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_t[0] <= ONE;
            r_t[1] <= 32'sd0;
            r_t[2] <= 32'sd0;
            r_t[3] <= 32'sd0;
            r_t[4] <= ONE;
            r_t[5] <= 32'sd0;
            unique case (i_operation)
                OP_TRANSLATE, OP_POINT: begin
                    r_t[2] <= i_arg_a;
                    r_t[5] <= i_arg_b;
                end
                OP_SCALE: begin
                    r_t[0] <= i_arg_a;
                    r_t[4] <= i_arg_b;
                end
                OP_SHEAR: begin
                    if (i_shear_axis) begin
                        r_t[1] <= i_arg_a;
                    end else begin
                        r_t[3] <= i_arg_a;
                    end
                end
                default: begin
                end
            endcase
            r_neg <= i_arg_a[31];
            r_dx  <= DX_W'(a_mag[31:FRAC_BITS]);
            r_lo  <= a_mag[FRAC_BITS-1:0];
        end
        if (i_cmd.div_quot) begin
            r_dq <= dprod[49:34];
        end
        if (i_cmd.mod_done) begin
            r_rmod <= rmod_v;
        end
        if (i_cmd.div_next) begin
            r_dx <= {rem0_n[8:0], low_n[31:16]};
            r_d0 <= low_n[15:0];
        end
        if (i_cmd.div_digit) begin
            r_bin <= {r_bin[15:0], r_dq};
            r_dx  <= {dr[8:0], r_d0};
        end
        if (i_cmd.cordic_init) begin
            r_q   <= quad;
            r_phi <= CORD_W'($signed({bin[31:30] - quad, bin[29:0]}));
            r_x   <= CORDIC_GAIN_Q30;
            r_y   <= '0;
        end
        if (i_cmd.cordic_step) begin
            if (!r_phi[CORD_W-1]) begin
                r_x   <= r_x - dx;
                r_y   <= r_y + dy;
                r_phi <= r_phi - at;
            end else begin
                r_x   <= r_x + dx;
                r_y   <= r_y - dy;
                r_phi <= r_phi + at;
            end
        end
        if (i_cmd.trig_load) begin
            r_t[0] <= cr[31:0];
            r_t[1] <= sr[31:0];
            r_t[3] <= 32'sd0 - sr[31:0];
            r_t[4] <= cr[31:0];
        end
        if (i_cmd.mul) begin
            r_prod <= prod;
        end
        if (i_cmd.acc_first) begin
            r_acc <= rp + ACC_W'(cterm);
        end
        if (i_cmd.acc_add) begin
            r_acc <= r_acc + rp;
        end
        if (i_cmd.store) begin
            unique case ({i_cmd.row, i_cmd.col})
                3'b000:  r_res[0] <= sat_val;
                3'b001:  r_res[1] <= sat_val;
                3'b010:  r_res[2] <= sat_val;
                3'b100:  r_res[3] <= sat_val;
                3'b101:  r_res[4] <= sat_val;
                default: r_res[5] <= sat_val;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m[0]  <= ONE;
            r_m[1]  <= 32'sd0;
            r_m[2]  <= 32'sd0;
            r_m[3]  <= 32'sd0;
            r_m[4]  <= ONE;
            r_m[5]  <= 32'sd0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.capture) begin
                r_ovf <= 1'b0;
            end else if (i_cmd.store && sat_hit) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.identity) begin
                r_m[0] <= ONE;
                r_m[1] <= 32'sd0;
                r_m[2] <= 32'sd0;
                r_m[3] <= 32'sd0;
                r_m[4] <= ONE;
                r_m[5] <= 32'sd0;
            end else if (i_cmd.commit) begin
                for (int i = 0; i < 6; i++) begin
                    r_m[i] <= r_res[i];
                end
            end
        end
    end

    assign o_x_out    = r_res[2];
    assign o_y_out    = r_res[5];
    assign o_overflow = r_ovf;
    assign o_valid    = r_valid;

endmodule
`default_nettype wire

@@ hdl/affine_2d_transform_engine_core.sv @@
// Top level of the 2D affine transform engine: sequencer plus datapath.
// A request is taken when start is high and busy is low. Identity loads and unused
// codes finish in the accepting cycle. Translate, scale and shear compute six dot
// products, each by multiply, accumulate, multiply, add and store on one shared
// 32x32 multiplier, then commit the new matrix. A point computes its x and y dot
// products and shows its result on o_x_out, o_y_out and o_overflow for one cycle
// with o_valid; the receiver cannot stall it. Rotate first reduces the angle with
// reciprocal multiplications by 1/360, then CORDIC_STEPS iterations give sine and
// cosine before the matrix update.
`default_nettype none
module affine_2d_transform_engine_core
    import aff2d_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         i_operation,
    input  wire logic signed [31:0] i_arg_a,
    input  wire logic signed [31:0] i_arg_b,
    input  wire logic               i_shear_axis,
    output logic                    o_valid,
    output logic signed [31:0]      o_x_out,
    output logic signed [31:0]      o_y_out,
    output logic                    o_overflow
);

    t_cmd cmd;

    aff2d_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_operation(i_operation),
        .busy       (busy),
        .o_cmd      (cmd)
    );

    aff2d_datapath #(
        .FRAC_BITS(FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_operation (i_operation),
        .i_arg_a     (i_arg_a),
        .i_arg_b     (i_arg_b),
        .i_shear_axis(i_shear_axis),
        .o_x_out     (o_x_out),
        .o_y_out     (o_y_out),
        .o_overflow  (o_overflow),
        .o_valid     (o_valid)
    );

endmodule
`default_nettype wire

@@ tb/sv/affine_2d_transform_engine_core_checker.sv @@
// Checker of the 2D affine transform engine: matrix predictor and result compare.
`timescale 1ns / 1ps
module affine_2d_transform_engine_core_checker
    import aff2d_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [2:0]         i_operation,
    input  wire logic signed [31:0] i_arg_a,
    input  wire logic signed [31:0] i_arg_b,
    input  wire logic               i_shear_axis,
    input  wire logic               o_valid,
    input  wire logic signed [31:0] o_x_out,
    input  wire logic signed [31:0] o_y_out,
    input  wire logic               o_overflow,
    output int                      o_fail_count,
    output int                      o_points_pending
);

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               ovf;
    } t_point;

    localparam longint ONE = longint'(1) << FRAC_BITS;
    localparam longint CORDIC_ATAN_COUNT = 30;

    longint mat[6];
    t_point point_q[$];
    int     fails;

    function automatic longint round_q(input longint v);
        return (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic longint clamp32(input longint v, inout logic ovf);
        if (v > 64'sd2147483647) begin
            ovf = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            ovf = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint dot2(input longint a0, input longint b0, input longint a1,
                                    input longint b1, input longint c, inout logic ovf);
        return clamp32(round_q(a0 * b0) + round_q(a1 * b1) + c, ovf);
    endfunction

    task automatic mat_post_mul(input longint t[6]);
        longint r[6];
        logic   dummy;
        dummy = 1'b0;
        for (int i = 0; i < 2; i++) begin
            r[3*i]   = dot2(mat[3*i], t[0], mat[3*i+1], t[3], 0, dummy);
            r[3*i+1] = dot2(mat[3*i], t[1], mat[3*i+1], t[4], 0, dummy);
            r[3*i+2] = dot2(mat[3*i], t[2], mat[3*i+1], t[5], mat[3*i+2], dummy);
        end
        for (int i = 0; i < 6; i++) mat[i] = r[i];
    endtask

    task automatic trig_of(input longint deg, output longint c, output longint s);
        longint full, r, phi, x, y, dx, dy, cc, ss;
        longint unsigned bin, q;
        full = longint'(360) << FRAC_BITS;
        r = deg % full;
        if (r < 0) r += full;
        bin = (longint'(unsigned'(r << (32 - FRAC_BITS))) + 180) / 360;
        bin &= 64'hFFFF_FFFF;
        q = ((bin + 64'h2000_0000) >> 30) & 3;
        phi = longint'(signed'(32'(bin - (q << 30))));
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS && i < CORDIC_ATAN_COUNT; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (phi >= 0) begin
                x -= dx;
                y += dy;
                phi -= longint'(atan_turn(5'(i)));
            end else begin
                x += dx;
                y -= dy;
                phi += longint'(atan_turn(5'(i)));
            end
        end
        case (q)
            0: begin cc = x;  ss = y;  end
            1: begin cc = -y; ss = x;  end
            2: begin cc = -x; ss = -y; end
            default: begin cc = y; ss = -x; end
        endcase
        c = (cc + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        s = (ss + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    endtask

    task automatic load_unit();
        for (int i = 0; i < 6; i++) mat[i] = 0;
        mat[0] = ONE;
        mat[4] = ONE;
    endtask

    task automatic predict_request(input logic [2:0] op, input longint a, input longint b,
                                   input logic axis);
        longint t[6];
        longint c, s;
        logic   ovf;
        t_point p;
        t = '{ONE, 0, 0, 0, ONE, 0};
        ovf = 1'b0;
        case (op)
            OP_IDENTITY: load_unit();
            OP_TRANSLATE: begin
                t[2] = a;
                t[5] = b;
                mat_post_mul(t);
            end
            OP_ROTATE: begin
                trig_of(a, c, s);
                t[0] = c;
                t[1] = s;
                t[3] = -s;
                t[4] = c;
                mat_post_mul(t);
            end
            OP_SCALE: begin
                t[0] = a;
                t[4] = b;
                mat_post_mul(t);
            end
            OP_SHEAR: begin
                if (axis == 1'b0) t[3] = a;
                else t[1] = a;
                mat_post_mul(t);
            end
            OP_POINT: begin
                p.x = 32'(dot2(mat[0], a, mat[1], b, mat[2], ovf));
                p.y = 32'(dot2(mat[3], a, mat[4], b, mat[5], ovf));
                p.ovf = ovf;
                point_q.push_back(p);
            end
            default: ;
        endcase
    endtask

    task automatic note_fail(input string msg);
        if (fails < 10) $display("%0t mismatch: %s", $realtime, msg);
        fails++;
    endtask

    initial begin
        load_unit();
        fails = 0;
    end

    always @(posedge i_clk) begin
        t_point e;
        if (i_rst_n) begin
            if (o_valid) begin
                if (point_q.size() == 0) begin
                    note_fail($sformatf("unexpected point x=%h y=%h ovf=%b",
                                        o_x_out, o_y_out, o_overflow));
                end else begin
                    e = point_q.pop_front();
                    if (o_x_out !== e.x || o_y_out !== e.y || o_overflow !== e.ovf)
                        note_fail($sformatf("exp x=%h y=%h ovf=%b act x=%h y=%h ovf=%b",
                                            e.x, e.y, e.ovf, o_x_out, o_y_out, o_overflow));
                end
            end
            if (start && !busy)
                predict_request(i_operation, longint'(i_arg_a), longint'(i_arg_b),
                                i_shear_axis);
        end
    end

    assign o_fail_count     = fails;
    assign o_points_pending = point_q.size();

endmodule

@@ tb/sv/affine_2d_transform_engine_core_test.sv @@
// Top of the 2D affine transform engine testbench: clock, reset, requests, verdict.
`timescale 1ns / 1ps
module affine_2d_transform_engine_core_test;
    import aff2d_pkg::*;

    localparam int RANDOM_REQUESTS = 930;
    localparam int CYCLE_LIMIT     = 800000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         i_operation;
    logic signed [31:0] i_arg_a;
    logic signed [31:0] i_arg_b;
    logic               i_shear_axis;
    logic               o_valid;
    logic signed [31:0] o_x_out;
    logic signed [31:0] o_y_out;
    logic               o_overflow;
    int                 fail_count;
    int                 points_pending;
    int                 cycles;
    logic               allow_gaps;

    affine_2d_transform_engine_core DUT (.*);

    affine_2d_transform_engine_core_checker u_checker (
        .*,
        .o_fail_count     (fail_count),
        .o_points_pending (points_pending)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("affine_2d_transform_engine_core_test: FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h0005_0000)) - 32'sh0002_8000);
        endcase
    endfunction

    function automatic logic [31:0] pick_factor();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'h0001_0000;
            default: return 32'($signed($urandom_range(0, 32'h0001_8000)) - 32'sh0000_C000);
        endcase
    endfunction

    function automatic logic [31:0] pick_angle();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 8)) * 45 - 180) << 16;
            default: return 32'($signed($urandom_range(0, 32'h0168_0000 * 2)) - 32'sh0168_0000);
        endcase
    endfunction

    task automatic send_request(input logic [2:0] op, input logic [31:0] a,
                                input logic [31:0] b, input logic axis);
        start        <= 1'b1;
        i_operation  <= op;
        i_arg_a      <= a;
        i_arg_b      <= b;
        i_shear_axis <= axis;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (allow_gaps && $urandom_range(0, 99) < 28) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    endtask

    task automatic send_random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 38) send_request(OP_POINT, pick_value(), pick_value(), 1'($urandom));
        else if (pick < 52) send_request(OP_ROTATE, pick_angle(), $urandom, 1'($urandom));
        else if (pick < 64) send_request(OP_TRANSLATE, pick_value(), pick_value(),
                                         1'($urandom));
        else if (pick < 76) send_request(OP_SCALE, pick_factor(), pick_factor(),
                                         1'($urandom));
        else if (pick < 88) send_request(OP_SHEAR, pick_factor(), $urandom, 1'($urandom));
        else if (pick < 96) send_request(OP_IDENTITY, $urandom, $urandom, 1'($urandom));
        else send_request(3'($urandom_range(6, 7)), $urandom, $urandom, 1'($urandom));
    endtask

    initial begin
        cycles       = 0;
        allow_gaps   = 1'b1;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_operation  = OP_IDENTITY;
        i_arg_a      = '0;
        i_arg_b      = '0;
        i_shear_axis = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(OP_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_request(OP_TRANSLATE, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_request(OP_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_request(OP_IDENTITY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_request(OP_SCALE, 32'h0002_0000, 32'hFFFF_0000, 1'b0);
        send_request(OP_POINT, 32'h4000_0000, 32'hC000_0000, 1'b0);
        send_request(OP_IDENTITY, 32'h0, 32'h0, 1'b0);
        send_request(OP_ROTATE, 32'h005A_0000, 32'h0, 1'b0);
        send_request(OP_POINT, 32'h0001_0000, 32'h0, 1'b0);
        send_request(OP_ROTATE, 32'h002D_0000, 32'hFFFF_FFFF, 1'b1);
        send_request(OP_ROTATE, 32'hFFA6_0000, 32'h0, 1'b0);
        send_request(OP_ROTATE, 32'h0168_0000, 32'h0, 1'b0);
        send_request(OP_ROTATE, 32'h8000_0000, 32'h0, 1'b0);
        send_request(OP_ROTATE, 32'h7FFF_FFFF, 32'h0, 1'b0);
        send_request(OP_POINT, 32'h0003_0000, 32'h0002_0000, 1'b0);
        send_request(OP_SHEAR, 32'h0000_8000, 32'h0, 1'b0);
        send_request(OP_SHEAR, 32'hFFFF_8000, 32'h0, 1'b1);
        send_request(OP_POINT, 32'h0001_0000, 32'h0001_0000, 1'b0);
        send_request(3'd6, 32'h1234_5678, 32'h0, 1'b0);
        send_request(3'd7, 32'h0, 32'h0, 1'b1);
        send_request(OP_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_request(OP_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_request(OP_IDENTITY, 32'h0, 32'h0, 1'b0);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            allow_gaps = !(n >= 300 && n < 500);
            send_random_request();
        end
        start <= 1'b0;

        while (points_pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && points_pending == 0) begin
            $display("affine_2d_transform_engine_core_test: PASS");
        end else begin
            $display("affine_2d_transform_engine_core_test: FAIL");
        end
        $finish;
    end

endmodule
